@@ rtl/core/ldct_pkg.sv @@
// ----------------------------------------------------------------------------
// ldct_pkg: shared types and constants of the lifting 8-point DCT
// Holds the pipeline control bundle, the output coefficient limits, the
// output scale table and the order in which coefficients leave the block.
// ----------------------------------------------------------------------------
package ldct_pkg;

	// Number of register stages from the input beat to the output register.
	localparam int NUM_STAGES = 12;

	// Output coefficient format.
	localparam int COEF_BITS = 16;
	localparam int COEF_MAX  = 32767;
	localparam int COEF_MIN  = -32768;

	// Output scale factors in Q30; each is rounded to the working fraction.
	localparam longint SCALE_Q30 [8] = '{
		64'sd379625062,
		64'sd547388835,
		64'sd581104888,
		64'sd645689156,
		64'sd759250125,
		64'sd446391849,
		64'sd496004047,
		64'sd526555088
	};

	// Which lifted value feeds each output coefficient.
	localparam int COEF_SRC [8] = '{0, 7, 3, 6, 1, 5, 2, 4};

	// Per-stage load strobes and valid flags shared by all datapath modules.
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctl_t;

	// Rounds a Q30 constant to nearest at the given number of fraction bits.
	function automatic longint q30_to_f(input longint k30, input int frac);
		int sh;
		sh = 30 - frac;
		return (k30 + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

endpackage

@@ rtl/core/ldct_sample_if.sv @@
// ----------------------------------------------------------------------------
// ldct_sample_if: input channel carrying eight signed samples per beat
// Valid/ready handshake; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface ldct_sample_if #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_0;
	logic signed [SAMPLE_BITS-1:0] sample_1;
	logic signed [SAMPLE_BITS-1:0] sample_2;
	logic signed [SAMPLE_BITS-1:0] sample_3;
	logic signed [SAMPLE_BITS-1:0] sample_4;
	logic signed [SAMPLE_BITS-1:0] sample_5;
	logic signed [SAMPLE_BITS-1:0] sample_6;
	logic signed [SAMPLE_BITS-1:0] sample_7;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3,
		output sample_4, sample_5, sample_6, sample_7,
		input  ready
	);

	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3,
		input  sample_4, sample_5, sample_6, sample_7,
		output ready
	);
endinterface

@@ rtl/core/ldct_coef_if.sv @@
// ----------------------------------------------------------------------------
// ldct_coef_if: output channel carrying eight DCT coefficients per beat
// Valid/ready handshake; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface ldct_coef_if ();
	logic                                valid;
	logic                                ready;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_0;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_1;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_2;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_3;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_4;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_5;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_6;
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_7;

	modport source (
		output valid, coef_0, coef_1, coef_2, coef_3,
		output coef_4, coef_5, coef_6, coef_7,
		input  ready
	);

	modport sink (
		input  valid, coef_0, coef_1, coef_2, coef_3,
		input  coef_4, coef_5, coef_6, coef_7,
		output ready
	);
endinterface

@@ rtl/core/ldct_ctl.sv @@
// ----------------------------------------------------------------------------
// ldct_ctl: valid/ready chain of the transform pipeline
// Tracks a valid flag per stage and lets a stage load whenever it is empty
// or the stage after it moves, so bubbles are squeezed out during a stall.
// ----------------------------------------------------------------------------
module ldct_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	output logic                in_ready,
	output ldct_pkg::pipe_ctl_t ctl
);
	localparam int N = ldct_pkg::NUM_STAGES;

	logic [N-1:0] valid_q;
	logic [N:0]   rdy;
	logic [N-1:0] vin;

	always_comb begin
		rdy[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		vin[0] = in_valid;
		for (int k = 1; k < N; k++) begin
			vin[k] = valid_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= vin[k];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign ctl.load  = rdy[N-1:0] & vin;
	assign ctl.valid = valid_q;
endmodule

@@ rtl/core/ldct_rot.sv @@
// ----------------------------------------------------------------------------
// ldct_rot: even butterfly and three-step lifting rotation (stages 2 to 8)
// The even half is delayed alongside the odd lifting chain, which alternates
// a multiply stage with a round-and-add stage.
// ----------------------------------------------------------------------------
module ldct_rot #(
	parameter int DATA_BITS = 30,
	parameter int FRAC_BITS = 14
) (
	input  logic                        clk,
	input  ldct_pkg::pipe_ctl_t         ctl,
	input  logic signed [DATA_BITS-1:0] a_s1 [8],
	output logic signed [DATA_BITS-1:0] b_s8 [8]
);
	localparam int KW = FRAC_BITS + 1;
	localparam int PW = DATA_BITS + KW;
	localparam logic signed [KW-1:0] C13_32 = KW'(13 << (FRAC_BITS - 5));
	localparam logic signed [KW-1:0] C11_16 = KW'(11 << (FRAC_BITS - 4));
	localparam logic signed [PW-1:0] HALF   = PW'(longint'(1) << (FRAC_BITS - 1));

	logic signed [DATA_BITS-1:0] e_s2 [4], e_s3 [4], e_s4 [4], e_s5 [4], e_s6 [4], e_s7 [4];
	logic signed [DATA_BITS-1:0] a4_s2, a5_s2, a6_s2, a7_s2;
	logic signed [DATA_BITS-1:0] a4_s3, a6_s3, a7_s3, t1_s3;
	logic signed [DATA_BITS-1:0] a4_s4, a6_s4, a7_s4, t1_s4;
	logic signed [DATA_BITS-1:0] a4_s5, a7_s5, t1_s5, t2_s5;
	logic signed [DATA_BITS-1:0] a4_s6, a7_s6, t1_s6, t2_s6;
	logic signed [DATA_BITS-1:0] a4_s7, a7_s7, t2_s7, u_s7;
	logic signed [PW-1:0]        p1_s2, p2_s4, p3_s6;
	logic signed [PW-1:0]        p1_r, p2_r, p3_r;

	// Products rounded half up back to the working fraction.
	assign p1_r = p1_s2 + HALF;
	assign p2_r = p2_s4 + HALF;
	assign p3_r = p3_s6 + HALF;

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			e_s2[0] <= a_s1[0] + a_s1[3];
			e_s2[1] <= a_s1[1] + a_s1[2];
			e_s2[2] <= a_s1[1] - a_s1[2];
			e_s2[3] <= a_s1[0] - a_s1[3];
			a4_s2   <= a_s1[4];
			a5_s2   <= a_s1[5];
			a6_s2   <= a_s1[6];
			a7_s2   <= a_s1[7];
			p1_s2   <= C13_32 * a_s1[6];
		end
		if (ctl.load[2]) begin
			e_s3  <= e_s2;
			a4_s3 <= a4_s2;
			a6_s3 <= a6_s2;
			a7_s3 <= a7_s2;
			t1_s3 <= a5_s2 - p1_r[FRAC_BITS +: DATA_BITS];
		end
		if (ctl.load[3]) begin
			e_s4  <= e_s3;
			a4_s4 <= a4_s3;
			a6_s4 <= a6_s3;
			a7_s4 <= a7_s3;
			t1_s4 <= t1_s3;
			p2_s4 <= C11_16 * t1_s3;
		end
		if (ctl.load[4]) begin
			e_s5  <= e_s4;
			a4_s5 <= a4_s4;
			a7_s5 <= a7_s4;
			t1_s5 <= t1_s4;
			t2_s5 <= p2_r[FRAC_BITS +: DATA_BITS] + a6_s4;
		end
		if (ctl.load[5]) begin
			e_s6  <= e_s5;
			a4_s6 <= a4_s5;
			a7_s6 <= a7_s5;
			t1_s6 <= t1_s5;
			t2_s6 <= t2_s5;
			p3_s6 <= C13_32 * t2_s5;
		end
		if (ctl.load[6]) begin
			e_s7  <= e_s6;
			a4_s7 <= a4_s6;
			a7_s7 <= a7_s6;
			t2_s7 <= t2_s6;
			u_s7  <= p3_r[FRAC_BITS +: DATA_BITS] - t1_s6;
		end
		if (ctl.load[7]) begin
			b_s8[0] <= e_s7[0];
			b_s8[1] <= e_s7[1];
			b_s8[2] <= e_s7[2];
			b_s8[3] <= e_s7[3];
			b_s8[4] <= a4_s7 + u_s7;
			b_s8[5] <= a4_s7 - u_s7;
			b_s8[6] <= a7_s7 - t2_s7;
			b_s8[7] <= a7_s7 + t2_s7;
		end
	end
endmodule

@@ rtl/core/ldct_post.sv @@
// ----------------------------------------------------------------------------
// ldct_post: second lifting stage and output scaling (stages 9 to 12)
// Seven lifts run side by side, then every coefficient is scaled, rounded
// half up and saturated into the output register.
// ----------------------------------------------------------------------------
module ldct_post #(
	parameter int DATA_BITS = 30,
	parameter int FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  ldct_pkg::pipe_ctl_t                   ctl,
	input  logic signed [DATA_BITS-1:0]           b_s8 [8],
	output logic signed [ldct_pkg::COEF_BITS-1:0] coef_s12 [8]
);
	localparam int KW = FRAC_BITS + 1;
	localparam int PW = DATA_BITS + KW;
	localparam int RW = PW - 2 * FRAC_BITS;
	localparam int EW = (RW > ldct_pkg::COEF_BITS) ? RW : ldct_pkg::COEF_BITS + 1;
	localparam logic signed [KW-1:0] C1_2   = KW'(1 << (FRAC_BITS - 1));
	localparam logic signed [KW-1:0] C13_32 = KW'(13 << (FRAC_BITS - 5));
	localparam logic signed [KW-1:0] C11_32 = KW'(11 << (FRAC_BITS - 5));
	localparam logic signed [KW-1:0] C11_16 = KW'(11 << (FRAC_BITS - 4));
	localparam logic signed [KW-1:0] C15_32 = KW'(15 << (FRAC_BITS - 5));
	localparam logic signed [KW-1:0] C3_16  = KW'(3 << (FRAC_BITS - 4));
	localparam logic signed [KW-1:0] C3_26  = KW'(((6 << FRAC_BITS) + 26) / 52);
	localparam logic signed [PW-1:0] LIFT_HALF = PW'(longint'(1) << (FRAC_BITS - 1));
	localparam logic signed [PW-1:0] FIN_HALF  = PW'(longint'(1) << (2 * FRAC_BITS - 1));
	localparam logic signed [EW-1:0] SAT_HI    = EW'(ldct_pkg::COEF_MAX);
	localparam logic signed [EW-1:0] SAT_LO    = EW'(ldct_pkg::COEF_MIN);

	logic signed [DATA_BITS-1:0] c0_s9;
	logic signed [DATA_BITS-1:0] base_s9 [1:7];
	logic signed [PW-1:0]        q_s9 [1:7];
	logic signed [PW-1:0]        qr [1:7];
	logic signed [DATA_BITS-1:0] r [1:7];
	logic signed [DATA_BITS-1:0] c_s10 [8];
	logic signed [PW-1:0]        f_s11 [8];

	always_comb begin
		for (int k = 1; k <= 7; k++) begin
			qr[k] = q_s9[k] + LIFT_HALF;
			r[k]  = qr[k][FRAC_BITS +: DATA_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			c0_s9   <= b_s8[0] + b_s8[1];
			q_s9[1] <= C1_2 * b_s8[0];
			q_s9[2] <= C13_32 * b_s8[3];
			q_s9[3] <= C11_32 * b_s8[2];
			q_s9[4] <= C3_26 * b_s8[7];
			q_s9[5] <= C11_16 * b_s8[6];
			q_s9[6] <= C15_32 * b_s8[5];
			q_s9[7] <= C3_16 * b_s8[4];
			for (int k = 1; k <= 7; k++) begin
				base_s9[k] <= b_s8[k];
			end
		end
		if (ctl.load[9]) begin
			c_s10[0] <= c0_s9;
			c_s10[1] <= r[1] - base_s9[1];
			c_s10[2] <= r[2] - base_s9[2];
			c_s10[3] <= base_s9[3] - r[3];
			c_s10[4] <= r[4] - base_s9[4];
			c_s10[5] <= base_s9[5] + r[5];
			c_s10[6] <= base_s9[6] - r[6];
			c_s10[7] <= base_s9[7] - r[7];
		end
	end

	for (genvar i = 0; i < 8; i++) begin : g_fin
		localparam logic signed [KW-1:0] SCALE =
			KW'(ldct_pkg::q30_to_f(ldct_pkg::SCALE_Q30[i], FRAC_BITS));

		logic signed [PW-1:0] fr;
		logic signed [RW-1:0] rq;
		logic signed [EW-1:0] re;

		assign fr = f_s11[i] + FIN_HALF;
		assign rq = fr[2 * FRAC_BITS +: RW];
		assign re = EW'(rq);

		always_ff @(posedge clk) begin
			if (ctl.load[10]) begin
				f_s11[i] <= c_s10[ldct_pkg::COEF_SRC[i]] * SCALE;
			end
			if (ctl.load[11]) begin
				if (re > SAT_HI) begin
					coef_s12[i] <= SAT_HI[ldct_pkg::COEF_BITS-1:0];
				end else if (re < SAT_LO) begin
					coef_s12[i] <= SAT_LO[ldct_pkg::COEF_BITS-1:0];
				end else begin
					coef_s12[i] <= re[ldct_pkg::COEF_BITS-1:0];
				end
			end
		end
	end
endmodule

@@ rtl/core/lifting_dct_8point.sv @@
// ----------------------------------------------------------------------------
// lifting_dct_8point: pipelined 8-point forward DCT built from lifting steps
// Eight signed samples go in per beat, eight scaled coefficients come out in
// natural frequency order, rounded to nearest and saturated to 16 bits.
// ----------------------------------------------------------------------------
// Usage
//   The samples channel takes one vector of eight samples per beat and the
//   coefs channel returns one vector of eight coefficients per beat, both
//   with a valid/ready handshake.
//   A beat taken at the samples channel passes through the twelve register
//   stages and shows as valid on the coefs channel once it reaches the last
//   of them, the output register. Throughput is one beat per cycle while the
//   receiver keeps ready high, since every stage may load in the cycle in
//   which the stage after it moves; the twelve register stages set only the
//   latency, and no stage holds more than one multiply or one round and add.
//   The transform holds no state between beats, so each result depends only
//   on its own samples.
//   Reset clears every stage's valid flag; the data registers are left as
//   they are and no result appears until a new beat has been taken.
//   When the receiver holds ready low, the result stays in the output
//   register and the stages behind it keep filling until each holds a beat;
//   only then is ready on the samples channel dropped. Nothing is lost or
//   sent twice.
// ----------------------------------------------------------------------------
module lifting_dct_8point #(
	parameter int SAMPLE_BITS    = 12,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	ldct_sample_if.sink samples,
	ldct_coef_if.source coefs
);
	// Working width: the largest lifted value stays below eight times the
	// sample range, so four extra integer bits cover every stage.
	localparam int DATA_BITS = SAMPLE_BITS + COEF_FRAC_BITS + 4;

	ldct_pkg::pipe_ctl_t         ctl;
	logic signed [SAMPLE_BITS-1:0] smp [8];
	logic signed [DATA_BITS-1:0]   x [8];
	logic signed [DATA_BITS-1:0]   a_s1 [8];
	logic signed [DATA_BITS-1:0]   b_s8 [8];
	logic signed [ldct_pkg::COEF_BITS-1:0] coef_s12 [8];

	// The stage valid flags and load strobes all come from one chain, so
	// every register stage can take a beat whenever the one after it moves.
	ldct_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.out_ready (coefs.ready),
		.in_ready  (samples.ready),
		.ctl       (ctl)
	);

	// Samples are sign extended and lifted into the working fraction.
	always_comb begin
		smp[0] = samples.sample_0;
		smp[1] = samples.sample_1;
		smp[2] = samples.sample_2;
		smp[3] = samples.sample_3;
		smp[4] = samples.sample_4;
		smp[5] = samples.sample_5;
		smp[6] = samples.sample_6;
		smp[7] = samples.sample_7;
		for (int i = 0; i < 8; i++) begin
			x[i] = DATA_BITS'(smp[i]) <<< COEF_FRAC_BITS;
		end
	end

	// Stage 1: the input butterfly pairs each sample with its mirror.
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			for (int i = 0; i < 4; i++) begin
				a_s1[i]     <= x[i] + x[7-i];
				a_s1[7-i]   <= x[i] - x[7-i];
			end
		end
	end

	// Stages 2 to 8: even butterfly and the odd-part lifting rotation.
	ldct_rot #(
		.DATA_BITS (DATA_BITS),
		.FRAC_BITS (COEF_FRAC_BITS)
	) u_rot (
		.clk  (clk),
		.ctl  (ctl),
		.a_s1 (a_s1),
		.b_s8 (b_s8)
	);

	// Stages 9 to 12: second lifts, scaling, rounding and saturation. The
	// last of these is the output register that faces the coefs channel.
	ldct_post #(
		.DATA_BITS (DATA_BITS),
		.FRAC_BITS (COEF_FRAC_BITS)
	) u_post (
		.clk      (clk),
		.ctl      (ctl),
		.b_s8     (b_s8),
		.coef_s12 (coef_s12)
	);

	assign coefs.valid  = ctl.valid[ldct_pkg::NUM_STAGES-1];
	assign coefs.coef_0 = coef_s12[0];
	assign coefs.coef_1 = coef_s12[1];
	assign coefs.coef_2 = coef_s12[2];
	assign coefs.coef_3 = coef_s12[3];
	assign coefs.coef_4 = coef_s12[4];
	assign coefs.coef_5 = coef_s12[5];
	assign coefs.coef_6 = coef_s12[6];
	assign coefs.coef_7 = coef_s12[7];
endmodule

@@ sim/dct8_coef_compare.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dct8_coef_compare: prediction and comparison for the lifting 8-point DCT
// Watches both channels. Every sample beat taken by the block is run through
// a bit-exact fixed-point model of the transform and the resulting vector is
// queued. Every coefficient beat is then compared field by field with the
// oldest vector in the queue.
// ----------------------------------------------------------------------------
module dct8_coef_compare #(
	parameter int SAMPLE_BITS    = 12,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic   clk,
	input  logic   arst_n,
	ldct_sample_if samples,
	ldct_coef_if   coefs,
	output int     errors,
	output int     pending,
	output int     checked
);
	localparam int FRAC = COEF_FRAC_BITS;
	localparam int CB   = ldct_pkg::COEF_BITS;

	typedef logic [7:0][SAMPLE_BITS-1:0] sample_vec_t;
	typedef logic [7:0][CB-1:0]          coef_vec_t;

	coef_vec_t coef_due_q [$];

	// Constant times value, both in the working fraction, rounded half up.
	function automatic longint lift_mul(input longint k, input longint v);
		return (k * v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	// Applies the scale of output slot k, rounds to an integer and saturates.
	function automatic logic [CB-1:0] scale_out(input longint v, input int k);
		longint s;
		longint r;
		s = (ldct_pkg::SCALE_Q30[k] + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
		r = (v * s + (longint'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
		if (r > ldct_pkg::COEF_MAX)
			r = ldct_pkg::COEF_MAX;
		if (r < ldct_pkg::COEF_MIN)
			r = ldct_pkg::COEF_MIN;
		return r[CB-1:0];
	endfunction

	function automatic coef_vec_t dct8_forward(input sample_vec_t s);
		longint x [8];
		longint a [8];
		longint b [8];
		longint c [8];
		longint t1, t2;
		longint k13_32, k11_16, k1_2, k11_32, k15_32, k3_16, k3_26;
		coef_vec_t r;
		k13_32 = longint'(13) <<< (FRAC - 5);
		k11_16 = longint'(11) <<< (FRAC - 4);
		k1_2   = longint'(1)  <<< (FRAC - 1);
		k11_32 = longint'(11) <<< (FRAC - 5);
		k15_32 = longint'(15) <<< (FRAC - 5);
		k3_16  = longint'(3)  <<< (FRAC - 4);
		k3_26  = ((longint'(6) <<< FRAC) + 26) / 52;
		for (int i = 0; i < 8; i++)
			x[i] = longint'($signed(s[i])) * (longint'(1) <<< FRAC);
		for (int i = 0; i < 4; i++) begin
			a[i]     = x[i] + x[7-i];
			a[7-i]   = x[i] - x[7-i];
		end
		b[0] = a[0] + a[3];
		b[1] = a[1] + a[2];
		b[2] = a[1] - a[2];
		b[3] = a[0] - a[3];
		// Odd part: three lifting steps forming the rotation.
		t1 = a[5] - lift_mul(k13_32, a[6]);
		t2 = lift_mul(k11_16, t1) + a[6];
		t1 = lift_mul(k13_32, t2) - t1;
		b[4] = a[4] + t1;
		b[5] = a[4] - t1;
		b[6] = a[7] - t2;
		b[7] = a[7] + t2;
		c[0] = b[0] + b[1];
		c[1] = lift_mul(k1_2, b[0]) - b[1];
		c[2] = lift_mul(k13_32, b[3]) - b[2];
		c[3] = b[3] - lift_mul(k11_32, b[2]);
		c[4] = lift_mul(k3_26, b[7]) - b[4];
		c[5] = b[5] + lift_mul(k11_16, b[6]);
		c[6] = b[6] - lift_mul(k15_32, b[5]);
		c[7] = b[7] - lift_mul(k3_16, b[4]);
		r[0] = scale_out(c[0], 0);
		r[1] = scale_out(c[7], 1);
		r[2] = scale_out(c[3], 2);
		r[3] = scale_out(c[6], 3);
		r[4] = scale_out(c[1], 4);
		r[5] = scale_out(c[5], 5);
		r[6] = scale_out(c[2], 6);
		r[7] = scale_out(c[4], 7);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		coef_vec_t seen;
		coef_vec_t due;
		int        err_count;
		int        done_count;
		err_count  = errors;
		done_count = checked;
		if (arst_n) begin
			if (coefs.valid && coefs.ready) begin
				seen = {coefs.coef_7, coefs.coef_6, coefs.coef_5, coefs.coef_4,
					coefs.coef_3, coefs.coef_2, coefs.coef_1, coefs.coef_0};
				if (coef_due_q.size() == 0) begin
					err_count++;
					$error("coefficient beat with no sample beat waiting for it");
				end else begin
					due = coef_due_q.pop_front();
					for (int k = 0; k < 8; k++) begin
						if (seen[k] !== due[k]) begin
							err_count++;
							$error("coef_%0d: expected %0d, actual %0d",
								k, $signed(due[k]), $signed(seen[k]));
						end
					end
					done_count++;
				end
			end
			if (samples.valid && samples.ready)
				coef_due_q.push_back(dct8_forward({samples.sample_7, samples.sample_6,
					samples.sample_5, samples.sample_4, samples.sample_3,
					samples.sample_2, samples.sample_1, samples.sample_0}));
		end
		errors  <= err_count;
		checked <= done_count;
		pending <= coef_due_q.size();
	end

endmodule

@@ sim/lifting_dct_8point_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifting_dct_8point_test: stimulus and verdict for the lifting 8-point DCT
// Drives sample vectors into the block through the valid/ready channel,
// first a directed set of extremes, then random vectors under four handshake
// pressure phases, while a companion module predicts and checks every
// coefficient beat.
// ----------------------------------------------------------------------------
module lifting_dct_8point_test;

	localparam int SAMPLE_BITS    = 12;
	localparam int COEF_FRAC_BITS = 14;
	// Cycles with no beat on either channel before the run is declared hung.
	// A correct run never comes near this: the pipeline is twelve stages and
	// the random gaps are geometric with short means.
	localparam int QUIET_LIMIT    = 4000;
	localparam int RANDOM_PER_PHASE = 383;

	typedef logic [7:0][SAMPLE_BITS-1:0] sample_vec_t;

	logic clk = 1'b0;
	logic arst_n;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int beats_sent     = 0;
	int quiet_cycles   = 0;

	int errors;
	int pending;
	int checked;

	ldct_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
	ldct_coef_if                                coefs_ch ();

	lifting_dct_8point #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.coefs   (coefs_ch)
	);

	dct8_coef_compare #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) compare (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.coefs   (coefs_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always #5 clk = ~clk;

	// The receiver drops ready at random, at the rate set for the current
	// phase. With a rate of zero it simply stays ready.
	always @(posedge clk) begin
		coefs_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: any beat on either side restarts the count of quiet cycles.
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (coefs_ch.valid && coefs_ch.ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no beat for %0d cycles, run abandoned", QUIET_LIMIT);
			$display("lifting_dct_8point_test: done, errors");
			$finish;
		end
	end

	// Random vector of one of three kinds: full-range uniform samples,
	// samples drawn mostly from the two extremes, or tiny values where the
	// rounding of every lifting step sits close to a tie.
	function automatic sample_vec_t random_vec();
		sample_vec_t v;
		int          mode;
		int          t;
		mode = $urandom_range(9);
		for (int k = 0; k < 8; k++) begin
			if (mode < 5) begin
				v[k] = SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1));
			end else if (mode < 8) begin
				case ($urandom_range(2))
					0:       v[k] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
					1:       v[k] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
					default: v[k] = SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1));
				endcase
			end else begin
				t    = int'($urandom_range(8)) - 4;
				v[k] = t[SAMPLE_BITS-1:0];
			end
		end
		return v;
	endfunction

	// Offers one sample vector and returns once the block has taken it.
	// Before the offer the sender may sit idle for a few cycles; the payload
	// is scrambled meanwhile so that any use of it with valid low shows up.
	// The task is always entered just after a rising edge, so valid gets a
	// single assignment per time step.
	task automatic push_beat(input sample_vec_t v);
		sample_vec_t junk;
		while ($urandom_range(99) < send_idle_pct) begin
			junk = random_vec();
			samples_ch.valid    <= 1'b0;
			samples_ch.sample_0 <= junk[0];
			samples_ch.sample_1 <= junk[1];
			samples_ch.sample_2 <= junk[2];
			samples_ch.sample_3 <= junk[3];
			samples_ch.sample_4 <= junk[4];
			samples_ch.sample_5 <= junk[5];
			samples_ch.sample_6 <= junk[6];
			samples_ch.sample_7 <= junk[7];
			@(posedge clk);
		end
		samples_ch.valid    <= 1'b1;
		samples_ch.sample_0 <= v[0];
		samples_ch.sample_1 <= v[1];
		samples_ch.sample_2 <= v[2];
		samples_ch.sample_3 <= v[3];
		samples_ch.sample_4 <= v[4];
		samples_ch.sample_5 <= v[5];
		samples_ch.sample_6 <= v[6];
		samples_ch.sample_7 <= v[7];
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	initial begin : stimulus
		sample_vec_t v;
		int          idle_tab  [4];
		int          stall_tab [4];
		// Phases: free flowing, sender mostly idle, receiver mostly stalling,
		// and both sides idling now and then.
		idle_tab  = '{0, 73, 0, 17};
		stall_tab = '{0, 0, 73, 17};

		// Every input of the block is known from time zero.
		arst_n              = 1'b0;
		samples_ch.valid    = 1'b0;
		samples_ch.sample_0 = '0;
		samples_ch.sample_1 = '0;
		samples_ch.sample_2 = '0;
		samples_ch.sample_3 = '0;
		samples_ch.sample_4 = '0;
		samples_ch.sample_5 = '0;
		samples_ch.sample_6 = '0;
		samples_ch.sample_7 = '0;
		coefs_ch.ready      = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with no idling on either side. It covers the all
		// zero vector, both rails on every sample, the alternating patterns
		// that drive the highest frequencies hardest, the half-and-half and
		// frequency-two patterns, a single extreme sample at each position,
		// and small values where the rounding ties lie.
		push_beat('0);
		push_beat({8{12'h7FF}});
		push_beat({8{12'h800}});
		push_beat({4{12'h800, 12'h7FF}});
		push_beat({4{12'h7FF, 12'h800}});
		push_beat({{4{12'h7FF}}, {4{12'h800}}});
		push_beat({{4{12'h800}}, {4{12'h7FF}}});
		push_beat({2{12'h7FF, 12'h800, 12'h800, 12'h7FF}});
		push_beat({2{12'h800, 12'h7FF, 12'h7FF, 12'h800}});
		for (int k = 0; k < 8; k++) begin
			v    = '0;
			v[k] = (k % 2 == 1) ? 12'h7FF : 12'h800;
			push_beat(v);
		end
		push_beat({8{12'h001}});
		push_beat({4{12'h001, 12'hFFF}});
		for (int k = 0; k < 8; k++)
			v[k] = SAMPLE_BITS'(k * 511 - 2048);
		push_beat(v);

		// Random part, one run of vectors per pressure phase.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_tab[p];
			recv_stall_pct = stall_tab[p];
			repeat (RANDOM_PER_PHASE)
				push_beat(random_vec());
		end
		samples_ch.valid <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		// Drain: wait for the last coefficient beat, then give the pipeline
		// time to show anything it should not.
		while (pending != 0)
			@(posedge clk);
		repeat (4 * ldct_pkg::NUM_STAGES) @(posedge clk);

		$display("sent %0d sample vectors (directed extremes, then random under four",
			beats_sent);
		$display("handshake pressure phases); %0d coefficient vectors compared", checked);
		if (errors == 0 && pending == 0) begin
			$display("lifting_dct_8point_test: done, clean");
		end else begin
			$display("lifting_dct_8point_test: done, errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/ldct_pkg.sv
rtl/core/ldct_sample_if.sv
rtl/core/ldct_coef_if.sv
rtl/core/ldct_ctl.sv
rtl/core/ldct_rot.sv
rtl/core/ldct_post.sv
rtl/core/lifting_dct_8point.sv
sim/dct8_coef_compare.sv
sim/lifting_dct_8point_test.sv
